[rtl/lse_pkg.sv]
package lse_pkg;

   localparam int WORD_W = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_VIEW = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEL_PUSH_OK = 2'd0,
      SEL_FULL    = 2'd1,
      SEL_EMPTY   = 2'd2,
      SEL_WORD    = 2'd3
   } out_sel_type;

   typedef struct packed {
      logic        push_wr;
      logic        pop_dec;
      logic        read_top;
      logic        read_next;
      logic        load_out;
      out_sel_type out_sel;
      logic        out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic ptr_zero;
      logic out_free;
   } dp_stat_type;

endpackage

[rtl/lse_channels.sv]
interface lse_req_if import lse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic signed [WORD_W-1:0] push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface lse_rsp_if import lse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] data_word;
   logic [ST_W-1:0]          status;
   logic                     empty_flag;
   logic                     full_flag;
   logic                     last_result;

   modport source (output valid, output data_word, output status, output empty_flag,
                   output full_flag, output last_result, input ready);
   modport sink   (input valid, input data_word, input status, input empty_flag,
                   input full_flag, input last_result, output ready);
endinterface

[rtl/lifo_stack_engine_core.sv]
// Channel   Dir  Handshake        Payload
// req_chan  in   valid / ready    opcode[1:0], push_value[31:0] signed
// rsp_chan  out  valid / ready    data_word[31:0] signed, status[1:0], empty_flag,
//                                 full_flag, last_result
//
// Push and any rejected operation: result registered on acceptance, valid in the next cycle.
// Pop, peek, view: the top word is first read into a registered memory output, then
// one result per cycle while rsp_chan takes them, paced by the single memory read port.
// Synchronous active-high reset clears the fill count and control; no clearing pass.
// rsp backpressure holds the output register and stalls the view walk; req_chan
// ready drops while a pop, peek or view transaction or an untaken result is in flight.
module lifo_stack_engine_core import lse_pkg::*; #(
   parameter int DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   lse_req_if.sink   req_chan,
   lse_rsp_if.source rsp_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   assign req_chan.ready = req_ready;

   lse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (op_type'(req_chan.opcode)),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lse_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .push_value      (req_chan.push_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_data_word   (rsp_chan.data_word),
      .rsp_status      (rsp_chan.status),
      .rsp_empty_flag  (rsp_chan.empty_flag),
      .rsp_full_flag   (rsp_chan.full_flag),
      .rsp_last_result (rsp_chan.last_result)
   );

endmodule

[rtl/lse_ctrl.sv]
module lse_ctrl import lse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  op_type      req_opcode,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      view_ff, view_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      view_in      = view_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.out_sel  = SEL_PUSH_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.out_last = 1'b1;
               unique case (req_opcode)
                  OP_PUSH: begin
                     cmd.load_out = 1'b1;
                     if (stat.full) begin
                        cmd.out_sel = SEL_FULL;
                     end else begin
                        cmd.push_wr = 1'b1;
                        cmd.out_sel = SEL_PUSH_OK;
                     end
                  end
                  OP_POP, OP_PEEK, OP_VIEW: begin
                     if (stat.empty) begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = SEL_EMPTY;
                     end else begin
                        cmd.read_top = 1'b1;
                        cmd.pop_dec  = (req_opcode == OP_POP);
                        view_in      = (req_opcode == OP_VIEW);
                        state_in     = S_EMIT;
                     end
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = SEL_WORD;
               cmd.out_last = !view_ff || stat.ptr_zero;
               if (cmd.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.read_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         view_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         view_ff  <= view_in;
      end
   end

   // a result without a memory read never leaves the idle state
   a_emit_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.read_top |=> state_ff == S_EMIT)
      else $error("read of top word not followed by emit");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == S_IDLE && stat.out_free)
      else $error("transaction accepted while busy");

   a_no_ready_in_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> !req_ready)
      else $error("input ready during result walk");

endmodule

[rtl/lse_datapath.sv]
module lse_datapath import lse_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [WORD_W-1:0] push_value,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_data_word,
   output logic [ST_W-1:0]          rsp_status,
   output logic                     rsp_empty_flag,
   output logic                     rsp_full_flag,
   output logic                     rsp_last_result
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WORD_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  top_idx, rd_addr;
   logic [WORD_W-1:0] rdata_ff;
   logic              rd_en;

   logic                     out_valid_ff, out_valid_in;
   logic signed [WORD_W-1:0] out_data_ff, out_data_in;
   status_type               out_status_ff, out_status_in;
   logic                     out_empty_ff, out_full_ff, out_last_ff;

   assign top_idx = IDX_W'(count_ff - CNT_W'(1));
   assign rd_en   = cmd.read_top || cmd.read_next;
   assign rd_addr = cmd.read_top ? top_idx : ptr_ff - IDX_W'(1);

   always_comb begin
      count_in = count_ff;
      if (cmd.push_wr) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      ptr_in = rd_en ? rd_addr : ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem[IDX_W'(count_ff)] <= push_value;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      out_data_in   = '0;
      out_status_in = ST_OK;
      unique case (cmd.out_sel)
         SEL_PUSH_OK: out_status_in = ST_OK;
         SEL_FULL:    out_status_in = ST_FULL;
         SEL_EMPTY:   out_status_in = ST_EMPTY;
         SEL_WORD:    out_data_in   = rdata_ff;
         default:     out_status_in = ST_OK;
      endcase
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff   <= out_data_in;
         out_status_ff <= out_status_in;
         out_empty_ff  <= (count_in == '0);
         out_full_ff   <= (count_in == CNT_W'(DEPTH));
         out_last_ff   <= cmd.out_last;
      end
   end

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign stat.ptr_zero = (ptr_ff == '0);
   assign stat.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_data_word   = out_data_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_empty_flag  = out_empty_ff;
   assign rsp_full_flag   = out_full_ff;
   assign rsp_last_result = out_last_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push_wr |-> count_ff < CNT_W'(DEPTH))
      else $error("write into full stack");

   a_walk_stays_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.read_next |-> !stat.ptr_zero && !cmd.read_top)
      else $error("view walk below bottom entry");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> stat.out_free)
      else $error("pending result overwritten");

endmodule
